// ===== rtl/b64d_pkg.sv =====
`timescale 1ns / 1ps
// Package for the base64 stream decoder: payload types, alphabet constants
// and the character-to-sextet lookup. No dependencies.
package b64d_pkg;

   localparam int CharW  = 8;
   localparam int CountW = 21;
   localparam int AccW   = 14;
   localparam int HeldW  = 4;
   localparam int SextW  = 6;

   // Sextet offsets of the alphabet ranges and the two symbol codes
   localparam logic [SextW-1:0] LowerBase = 6'd26;
   localparam logic [SextW-1:0] DigitBase = 6'd52;
   localparam logic [SextW-1:0] PlusCode  = 6'd62;
   localparam logic [SextW-1:0] SlashCode = 6'd63;

   localparam logic [HeldW-1:0] SextetBits = 4'd6;
   localparam logic [HeldW-1:0] ByteBits   = 4'd8;

   typedef struct packed {
      logic [CharW-1:0]  char_code;
      logic              start_of_string;
      logic              end_of_string;
      logic [CountW-1:0] room_bytes;
   } req_payload_type;

   typedef struct packed {
      logic [CharW-1:0]  byte_value;
      logic              byte_valid;
      logic [CountW-1:0] written_count;
      logic              string_done;
   } rsp_payload_type;

   typedef struct packed {
      logic             hit;
      logic [SextW-1:0] value;
   } sextet_type;

   function automatic sextet_type sextet_of(input logic [CharW-1:0] c);
      sextet_type r;
      r.hit   = 1'b1;
      r.value = '0;
      if (c inside {[8'h41:8'h5A]}) begin
         r.value = 6'(c - 8'h41);
      end else if (c inside {[8'h61:8'h7A]}) begin
         r.value = 6'(c - 8'h61) + LowerBase;
      end else if (c inside {[8'h30:8'h39]}) begin
         r.value = 6'(c - 8'h30) + DigitBase;
      end else if (c == 8'h2B) begin
         r.value = PlusCode;
      end else if (c == 8'h2F) begin
         r.value = SlashCode;
      end else begin
         r.hit = 1'b0;
      end
      return r;
   endfunction

endpackage

// ===== rtl/b64d_stream_if.sv =====
`timescale 1ns / 1ps
// Valid/ready stream channel carrying one payload struct per transfer.
// Depends on nothing; payload type is given by the instantiating module.
interface b64d_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/b64d_core.sv =====
`timescale 1ns / 1ps
// Decode datapath: sextet lookup, bit accumulator, room check and counters.
// Depends on b64d_pkg.
module b64d_core #(
   parameter int unsigned MAX_ROOM_BYTES = 1048576
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     take,
   input  b64d_pkg::req_payload_type req_data,
   output logic                     has_result,
   output b64d_pkg::rsp_payload_type rsp_data
);
   import b64d_pkg::*;

   localparam logic [CountW+3:0] MaxRoom = (CountW+4)'(MAX_ROOM_BYTES);

   logic [AccW-1:0]   acc_ff, acc_in;
   logic [HeldW-1:0]  held_ff, held_in;
   logic [CountW-1:0] wr_ff, wr_in;
   logic [CountW-1:0] limit_ff, limit_in;

   logic [AccW-1:0]   acc_base;
   logic [HeldW-1:0]  held_base;
   logic [HeldW-1:0]  held_sum;
   logic [CountW-1:0] wr_base;
   logic [CountW-1:0] room_sat;
   sextet_type        sext;
   logic              emit;
   logic [CharW-1:0]  value;

   always_comb begin
      sext = sextet_of(req_data.char_code);
      if ({4'b0, req_data.room_bytes} > MaxRoom) begin
         room_sat = MaxRoom[CountW-1:0];
      end else begin
         room_sat = req_data.room_bytes;
      end

      acc_base  = req_data.start_of_string ? '0 : acc_ff;
      held_base = req_data.start_of_string ? '0 : held_ff;
      wr_base   = req_data.start_of_string ? '0 : wr_ff;
      limit_in  = req_data.start_of_string ? room_sat : limit_ff;

      acc_in   = acc_base;
      held_in  = held_base;
      wr_in    = wr_base;
      held_sum = held_base + SextetBits;
      emit     = 1'b0;
      value    = '0;
      if (sext.hit) begin
         acc_in  = {acc_base[AccW-SextW-1:0], sext.value};
         held_in = held_sum;
         if (held_sum >= ByteBits) begin
            held_in = held_sum - ByteBits;
            // byte leaves the accumulator even when there is no room for it
            if (wr_base < limit_in) begin
               emit  = 1'b1;
               value = 8'(acc_in >> held_in);
               wr_in = wr_base + 1'b1;
            end
         end
      end

      has_result             = emit || req_data.end_of_string;
      rsp_data.byte_value    = value;
      rsp_data.byte_valid    = emit;
      rsp_data.written_count = wr_in;
      rsp_data.string_done   = req_data.end_of_string;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         held_ff  <= '0;
         wr_ff    <= '0;
         limit_ff <= '0;
      end else if (take) begin
         acc_ff   <= acc_in;
         held_ff  <= held_in;
         wr_ff    <= wr_in;
         limit_ff <= limit_in;
      end
   end

   held_even: assert property (@(posedge clock) disable iff (reset)
      !held_ff[0] && held_ff <= SextetBits)
      else $error("bit count left an even value in 0..6");

   within_room: assert property (@(posedge clock) disable iff (reset)
      wr_ff <= limit_ff)
      else $error("written count passed the sampled room");

   count_steps: assert property (@(posedge clock) disable iff (reset)
      take && !req_data.start_of_string |=> wr_ff == $past(wr_ff) || wr_ff == $past(wr_ff) + 1'b1)
      else $error("written count moved by more than one byte");

endmodule

// ===== rtl/b64d_rsp_buf.sv =====
`timescale 1ns / 1ps
// Result output register with a skid entry, so input keeps flowing while
// a result waits. Depends on b64d_pkg and b64d_stream_if.
module b64d_rsp_buf (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  b64d_pkg::rsp_payload_type in_data,
   output logic                      in_ready,
   b64d_stream_if.source             rsp_if
);
   import b64d_pkg::*;

   logic            out_v_ff, out_v_in;
   logic            skid_v_ff, skid_v_in;
   rsp_payload_type out_ff, out_in;
   rsp_payload_type skid_ff, skid_in;
   logic            out_take;

   assign out_take       = out_v_ff && rsp_if.ready;
   assign in_ready       = !skid_v_ff;
   assign rsp_if.valid   = out_v_ff;
   assign rsp_if.payload = out_ff;

   always_comb begin
      out_v_in  = out_v_ff;
      skid_v_in = skid_v_ff;
      out_in    = out_ff;
      skid_in   = skid_ff;
      if (skid_v_ff) begin
         if (out_take) begin
            out_in    = skid_ff;
            skid_v_in = 1'b0;
         end
      end else if (in_valid) begin
         if (!out_v_ff || out_take) begin
            out_in   = in_data;
            out_v_in = 1'b1;
         end else begin
            skid_in   = in_data;
            skid_v_in = 1'b1;
         end
      end else if (out_take) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid entry held while output register empty");

   skid_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_v_ff) |-> $past(out_v_ff && !rsp_if.ready))
      else $error("skid entry filled although output was free");

   skid_drains_first: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff && out_take |=> out_v_ff && out_ff == $past(skid_ff))
      else $error("skid entry lost or reordered");

endmodule

// ===== rtl/base64_stream_decoder.sv =====
`timescale 1ns / 1ps
// channel   dir  handshake              payload
// req_if    in   valid/ready            char_code, start_of_string, end_of_string, room_bytes
// rsp_if    out  valid/ready            byte_value, byte_valid, written_count, string_done
//
// One character is taken per clock while the skid entry is empty; its result (if any) goes
// to the output register. Decode is a single pass from the state registers.
// A stalled result parks in a skid entry; req_if.ready drops only when that entry is full.
// Characters that yield no byte and are not last give no result.
// Synchronous reset clears accumulator, counts and room (no bytes until a start).
// Depends on b64d_pkg, b64d_stream_if, b64d_core and b64d_rsp_buf.
module base64_stream_decoder #(
   parameter int unsigned MAX_ROOM_BYTES = 1048576
) (
   input logic           clock,
   input logic           reset,
   b64d_stream_if.sink   req_if,
   b64d_stream_if.source rsp_if
);
   import b64d_pkg::*;

   logic            take;
   logic            has_result;
   logic            buf_ready;
   rsp_payload_type result;

   assign req_if.ready = buf_ready;
   assign take         = req_if.valid && buf_ready;

   b64d_core #(
      .MAX_ROOM_BYTES(MAX_ROOM_BYTES)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .req_data  (req_if.payload),
      .has_result(has_result),
      .rsp_data  (result)
   );

   b64d_rsp_buf u_rsp_buf (
      .clock   (clock),
      .reset   (reset),
      .in_valid(take && has_result),
      .in_data (result),
      .in_ready(buf_ready),
      .rsp_if  (rsp_if)
   );

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for base64_stream_decoder: random and directed base64 strings,
// decoded bytes and string totals checked against an in-bench decoder model.
// Depends on b64d_pkg, b64d_stream_if and the decoder RTL.
module tb;
   import b64d_pkg::*;

   localparam int unsigned RoomCap    = 1048576;
   localparam int          CycleLimit = 400000;
   localparam int          RandItems  = 700;

   logic clock;
   logic reset;

   b64d_stream_if #(.payload_type(req_payload_type)) req_ch ();
   b64d_stream_if #(.payload_type(rsp_payload_type)) rsp_ch ();

   base64_stream_decoder #(.MAX_ROOM_BYTES(RoomCap)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch.sink),
      .rsp_if (rsp_ch.source)
   );

   // decoder model state
   logic [AccW-1:0]   acc_bits;
   logic [HeldW-1:0]  held_bits;
   logic [CountW-1:0] bytes_out;
   logic [CountW-1:0] room_limit;

   req_payload_type pending_chars[$];
   rsp_payload_type expected_bytes[$];

   logic req_fire;
   logic rsp_fire;
   bit   no_idle;
   int   send_wait;
   int   sink_wait;
   int   error_count;
   int   cycle_count;

   string alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int draw_wait();
      return no_idle ? 0 : $urandom_range(0, 10);
   endfunction

   function automatic sextet_type char_to_sextet(input logic [CharW-1:0] c);
      sextet_type s;
      s.hit   = 1'b1;
      s.value = '0;
      if (c >= "A" && c <= "Z") s.value = SextW'(c - "A");
      else if (c >= "a" && c <= "z") s.value = SextW'(c - "a") + LowerBase;
      else if (c >= "0" && c <= "9") s.value = SextW'(c - "0") + DigitBase;
      else if (c == "+") s.value = PlusCode;
      else if (c == "/") s.value = SlashCode;
      else s.hit = 1'b0;
      return s;
   endfunction

   task automatic decode_char(input req_payload_type c);
      sextet_type      s;
      rsp_payload_type r;
      r = '0;
      if (c.start_of_string) begin
         acc_bits   = '0;
         held_bits  = '0;
         bytes_out  = '0;
         room_limit = (c.room_bytes > RoomCap) ? CountW'(RoomCap) : c.room_bytes;
      end
      s = char_to_sextet(c.char_code);
      if (s.hit) begin
         acc_bits  = {acc_bits[AccW-SextW-1:0], s.value};
         held_bits = held_bits + SextetBits;
         if (held_bits >= ByteBits) begin
            held_bits = held_bits - ByteBits;
            // byte is consumed even when it does not fit the room
            if (bytes_out < room_limit) begin
               r.byte_value = 8'(acc_bits >> held_bits);
               r.byte_valid = 1'b1;
               bytes_out    = bytes_out + 1'b1;
            end
         end
      end
      if (r.byte_valid || c.end_of_string) begin
         r.written_count = bytes_out;
         r.string_done   = c.end_of_string;
         expected_bytes.push_back(r);
      end
   endtask

   task automatic report(input string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   // acceptance, prediction, checking and the timeout
   always @(posedge clock) begin
      rsp_payload_type want;
      rsp_payload_type got;
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("Test completed with failures");
         $finish;
      end else if (reset) begin
         req_fire <= 1'b0;
         rsp_fire <= 1'b0;
      end else begin
         req_fire <= req_ch.valid && req_ch.ready;
         rsp_fire <= rsp_ch.valid && rsp_ch.ready;
         if (req_ch.valid && req_ch.ready) decode_char(req_ch.payload);
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.payload;
            if (expected_bytes.size() == 0) begin
               report($sformatf("unexpected result %p", got));
            end else begin
               want = expected_bytes.pop_front();
               if (got.byte_value !== want.byte_value)
                  report($sformatf("byte_value %0h, want %0h", got.byte_value, want.byte_value));
               if (got.byte_valid !== want.byte_valid)
                  report($sformatf("byte_valid %0b, want %0b", got.byte_valid, want.byte_valid));
               if (got.written_count !== want.written_count)
                  report($sformatf("written_count %0d, want %0d",
                                   got.written_count, want.written_count));
               if (got.string_done !== want.string_done)
                  report($sformatf("string_done %0b, want %0b", got.string_done, want.string_done));
            end
         end
      end
   end

   // character driver
   always @(negedge clock) begin
      logic next_valid;
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_wait = draw_wait();
      end else begin
         next_valid = req_ch.valid;
         if (req_fire) begin
            next_valid = 1'b0;
            send_wait  = draw_wait();
         end
         if (!next_valid) begin
            if (send_wait > 0) begin
               send_wait--;
            end else if (pending_chars.size() > 0) begin
               req_ch.payload <= pending_chars.pop_front();
               next_valid = 1'b1;
            end
         end
         req_ch.valid <= next_valid;
      end
   end

   // result sink: after each transfer, holds ready low for a randomly drawn wait
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         sink_wait = draw_wait();
      end else begin
         if (rsp_fire) sink_wait = draw_wait();
         if (sink_wait > 0) begin
            sink_wait--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic push_char(input logic [7:0] c, input logic sos, input logic eos,
                            input logic [CountW-1:0] room);
      req_payload_type it;
      it.char_code       = c;
      it.start_of_string = sos;
      it.end_of_string   = eos;
      it.room_bytes      = room;
      pending_chars.push_back(it);
   endtask

   function automatic logic [7:0] any_alpha();
      return alphabet[$urandom_range(0, 63)];
   endfunction

   function automatic logic [CountW-1:0] pick_room(input int n_chars);
      case ($urandom_range(0, 9))
         0:       return '0;
         1, 2, 3: return CountW'($urandom_range(0, 8));
         4, 5, 6: return CountW'($urandom_range(0, n_chars));
         7:       return CountW'($urandom_range(0, (1 << CountW) - 1));
         8:       return CountW'($urandom_range(RoomCap, (1 << CountW) - 1));
         default: return CountW'($urandom_range(n_chars, 4 * n_chars));
      endcase
   endfunction

   // one random string; returns the number of its characters that are in the alphabet or carry the end flag
   task automatic queue_string(output int counted);
      int                n_chars;
      int                mode;
      logic [7:0]        c;
      logic              sos;
      logic              eos;
      logic [CountW-1:0] room;
      sextet_type        sx;
      counted = 0;
      n_chars = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 16);
      mode    = $urandom_range(0, 9);
      room    = pick_room(n_chars);
      for (int k = 0; k < n_chars; k++) begin
         if ($urandom_range(0, 11) == 0)
            c = ($urandom_range(0, 2) == 0) ? "=" : 8'($urandom_range(0, 255));
         else
            c = any_alpha();
         if (mode == 9) begin
            // broken framing: flags at random
            sos = ($urandom_range(0, 7) == 0);
            eos = ($urandom_range(0, 7) == 0);
         end else begin
            sos = (k == 0) && (mode != 8);
            eos = (k == n_chars - 1);
         end
         push_char(c, sos, eos, sos ? room : CountW'($urandom));
         sx = char_to_sextet(c);
         if (sx.hit || eos) counted++;
      end
      // occasional trailing padding after the end marker
      if ($urandom_range(0, 5) == 0) push_char("=", 1'b0, 1'b0, CountW'($urandom));
   endtask

   initial begin
      int made;
      int got;
      int strings;
      reset = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready   = 1'b0;
      acc_bits    = '0;
      held_bits   = '0;
      bytes_out   = '0;
      room_limit  = '0;
      error_count = 0;
      cycle_count = 0;
      no_idle     = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // no start seen yet: room is zero, no bytes emitted
      push_char("Q", 1'b0, 1'b0, 21'd9);
      push_char("U", 1'b0, 1'b0, 21'd9);
      push_char("F", 1'b0, 1'b1, 21'd9);
      // start and end together
      push_char("z", 1'b1, 1'b1, 21'd5);
      // "Man", exactly fitting
      push_char("T", 1'b1, 1'b0, 21'd3);
      push_char("W", 1'b0, 1'b0, '0);
      push_char("F", 1'b0, 1'b0, '0);
      push_char("u", 1'b0, 1'b1, '0);
      // characters after the end continue the string; leftover bits then discarded
      push_char("0", 1'b0, 1'b0, '1);
      push_char("9", 1'b0, 1'b1, '1);
      // room exhausted after one byte
      push_char("+", 1'b1, 1'b0, 21'd1);
      push_char("/", 1'b0, 1'b0, '0);
      push_char("a", 1'b0, 1'b0, '0);
      push_char("Z", 1'b0, 1'b1, '0);
      // room above the cap, skipped last characters, extreme codes
      push_char("/", 1'b1, 1'b0, '1);
      push_char("/", 1'b0, 1'b0, '0);
      push_char(8'h00, 1'b0, 1'b0, '0);
      push_char(8'hFF, 1'b0, 1'b0, '1);
      push_char("A", 1'b0, 1'b0, '0);
      push_char("=", 1'b0, 1'b1, '0);
      push_char("A", 1'b1, 1'b0, 21'h100000);
      push_char("A", 1'b0, 1'b0, '0);
      push_char("=", 1'b0, 1'b0, '0);
      push_char("=", 1'b0, 1'b1, '0);

      made = 0;
      while (made < RandItems) begin
         while (pending_chars.size() > 0) @(posedge clock);
         no_idle = ($urandom_range(0, 3) == 0);
         strings = $urandom_range(4, 10);
         for (int s = 0; s < strings; s++) begin
            queue_string(got);
            made += got;
         end
      end

      while (pending_chars.size() > 0 || req_ch.valid || expected_bytes.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/b64d_pkg.sv
rtl/b64d_stream_if.sv
rtl/b64d_core.sv
rtl/b64d_rsp_buf.sv
rtl/base64_stream_decoder.sv
bench/tb.sv
